// ----- rtl/core/assert_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gpio_pkg.sv -----
`timescale 1ns / 1ps

package gpio_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned BankW     = 2;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned IrqW      = 4;
  localparam int unsigned NumBanksDefault = 4;

  // item kind, carried in tuser
  typedef enum logic [CmdW-1:0] {
    CmdRead   = 2'd0,
    CmdWrite  = 2'd1,
    CmdSample = 2'd2
  } cmd_e;

  // register word offsets (byte offset / 4)
  localparam logic [AddrW-1:0] RegData  = 5'd0;
  localparam logic [AddrW-1:0] RegDir   = 5'd1;
  localparam logic [AddrW-1:0] RegInten = 5'd12;
  localparam logic [AddrW-1:0] RegMask  = 5'd13;
  localparam logic [AddrW-1:0] RegType  = 5'd14;
  localparam logic [AddrW-1:0] RegPol   = 5'd15;
  localparam logic [AddrW-1:0] RegStat  = 5'd16;
  localparam logic [AddrW-1:0] RegEoi   = 5'd19;
  localparam logic [AddrW-1:0] RegExt   = 5'd20;

  // request from the input register to one bank
  typedef struct packed {
    logic             en;
    logic [CmdW-1:0]  cmd;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] pins;
  } bank_req_t;

  // bank state as it stands after the request
  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic [DataW-1:0] out_data;
    logic [DataW-1:0] direction;
    logic             irq;
  } bank_view_t;

  // one result transfer
  typedef struct packed {
    logic [IrqW-1:0]  irq_lines;
    logic [DataW-1:0] pin_oe;
    logic [DataW-1:0] pin_out;
    logic [DataW-1:0] rdata;
  } result_t;

endpackage

// ----- rtl/core/gpio_bank.sv -----
`timescale 1ns / 1ps

module gpio_bank
  import gpio_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bank_req_t  req_i,
  output bank_view_t view_o
);

  logic [DataW-1:0] out_data_q, out_data_d;
  logic [DataW-1:0] dir_q, dir_d;
  logic [DataW-1:0] inten_q, inten_d;
  logic [DataW-1:0] mask_q, mask_d;
  logic [DataW-1:0] type_q, type_d;
  logic [DataW-1:0] pol_q, pol_d;
  logic [DataW-1:0] latch_q, latch_d;
  logic [DataW-1:0] pins_q, pins_d;

  logic [DataW-1:0] rise, fall, hit, level_on, status;

  assign rise = req_i.pins & ~pins_q;
  assign fall = pins_q & ~req_i.pins;
  assign hit  = (pol_q & rise) | (~pol_q & fall);

  always_comb begin
    out_data_d = out_data_q;
    dir_d      = dir_q;
    inten_d    = inten_q;
    mask_d     = mask_q;
    type_d     = type_q;
    pol_d      = pol_q;
    latch_d    = latch_q;
    pins_d     = pins_q;
    if (req_i.en && req_i.cmd == CmdWrite) begin
      unique case (req_i.addr)
        RegData:  out_data_d = req_i.wdata;
        RegDir:   dir_d      = req_i.wdata;
        RegInten: inten_d    = req_i.wdata;
        RegMask:  mask_d     = req_i.wdata;
        RegType:  type_d     = req_i.wdata;
        RegPol:   pol_d      = req_i.wdata;
        RegEoi:   latch_d    = latch_q & ~req_i.wdata;
        default:  ;
      endcase
    end else if (req_i.en && req_i.cmd == CmdSample) begin
      latch_d = latch_q | (hit & inten_q & type_q);
      pins_d  = req_i.pins;
    end
  end

  // status on the updated state
  assign level_on = ~(pins_d ^ pol_d);
  assign status   = inten_d & ~mask_d & ((type_d & latch_d) | (~type_d & level_on));

  always_comb begin
    view_o.out_data  = out_data_d;
    view_o.direction = dir_d;
    view_o.irq       = |status;
    unique case (req_i.addr)
      RegData:  view_o.rdata = out_data_d;
      RegDir:   view_o.rdata = dir_d;
      RegInten: view_o.rdata = inten_d;
      RegMask:  view_o.rdata = mask_d;
      RegType:  view_o.rdata = type_d;
      RegPol:   view_o.rdata = pol_d;
      RegStat:  view_o.rdata = status;
      RegExt:   view_o.rdata = pins_d;
      default:  view_o.rdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_data_q <= '0;
      dir_q      <= '0;
      inten_q    <= '0;
      mask_q     <= '0;
      type_q     <= '0;
      pol_q      <= '0;
      latch_q    <= '0;
      pins_q     <= '0;
    end else begin
      out_data_q <= out_data_d;
      dir_q      <= dir_d;
      inten_q    <= inten_d;
      mask_q     <= mask_d;
      type_q     <= type_d;
      pol_q      <= pol_d;
      latch_q    <= latch_d;
      pins_q     <= pins_d;
    end
  end

endmodule

// ----- rtl/core/gpio_out_stage.sv -----
`timescale 1ns / 1ps

module gpio_out_stage
  import gpio_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t data_i,
  output logic    can_load_o,
  output logic    tvalid_o,
  input  logic    tready_i,
  output result_t data_o
);

  logic    vld_q;
  result_t data_q;

  assign can_load_o = !vld_q || tready_i;
  assign tvalid_o   = vld_q;
  assign data_o     = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (can_load_o) begin
      vld_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && can_load_o) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- rtl/core/gpio_port_with_interrupts_core.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// GPIO core with interrupts: up to four addressable banks of 32 pins, each with output data,
// direction, interrupt enable, mask, type (1 = edge, 0 = level) and polarity registers,
// latched edge flags and the last pin sample. Every slave transfer is a register read,
// a register write or a pin sample for one bank (kind in tuser) and yields exactly one
// master transfer carrying the read data (zero unless a read), the addressed bank's output
// levels and output enables, and one interrupt line per bank, all taken after the item's
// update. Unknown or write-only offsets read as zero; writes to unknown or read-only offsets
// and items for absent banks change nothing. The block takes one transfer per cycle and
// holds each item first in the input register, then in the result register; all bank
// logic between them is combinational. A stalled master side holds the slave side only
// once both registers are full.
module gpio_port_with_interrupts_core
  import gpio_pkg::*;
#(
  parameter int unsigned NUM_BANKS = NumBanksDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [1:0] bank, [6:2] addr, [38:7] wdata, [70:39] pins, [71] zero
  input  logic [71:0]   s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [31:0] rdata, [63:32] pin_out, [95:64] pin_oe, [99:96] irq_lines, [103:100] zero
  output logic [103:0]  m_axis_tdata
);

  // only banks reachable by the 2-bit bank field carry state
  localparam int unsigned LiveBanks = (NUM_BANKS < (1 << BankW)) ? NUM_BANKS : (1 << BankW);
  localparam logic [IrqW-1:0] IrqLive = IrqW'((1 << LiveBanks) - 1);

  // input register
  logic             in_vld_q;
  logic [CmdW-1:0]  in_cmd_q;
  logic [BankW-1:0] in_bank_q;
  logic [AddrW-1:0] in_addr_q;
  logic [DataW-1:0] in_wdata_q;
  logic [DataW-1:0] in_pins_q;

  logic       advance;
  logic       can_load;
  logic       in_fire;
  result_t    result;
  result_t    out_data;
  bank_req_t  req   [LiveBanks];
  bank_view_t view  [LiveBanks];

  assign advance       = in_vld_q && can_load;
  assign s_axis_tready = !in_vld_q || can_load;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_cmd_q   <= s_axis_tuser;
      in_bank_q  <= s_axis_tdata[1:0];
      in_addr_q  <= s_axis_tdata[6:2];
      in_wdata_q <= s_axis_tdata[38:7];
      in_pins_q  <= s_axis_tdata[70:39];
    end
  end

  // banks: state updates only when the item leaves the input register
  for (genvar b = 0; b < LiveBanks; b++) begin : g_bank
    always_comb begin
      req[b].en    = advance && (in_bank_q == BankW'(b));
      req[b].cmd   = in_cmd_q;
      req[b].addr  = in_addr_q;
      req[b].wdata = in_wdata_q;
      req[b].pins  = in_pins_q;
    end

    gpio_bank u_bank (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .req_i  (req[b]),
      .view_o (view[b])
    );
  end

  // result select; absent banks give zeros
  always_comb begin
    result = '0;
    for (int unsigned b = 0; b < LiveBanks; b++) begin
      result.irq_lines[b] = view[b].irq;
      if (in_bank_q == BankW'(b)) begin
        result.pin_out = view[b].out_data;
        result.pin_oe  = view[b].direction;
        if (in_cmd_q == CmdRead) begin
          result.rdata = view[b].rdata;
        end
      end
    end
  end

  gpio_out_stage u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (in_vld_q),
    .data_i     (result),
    .can_load_o (can_load),
    .tvalid_o   (m_axis_tvalid),
    .tready_i   (m_axis_tready),
    .data_o     (out_data)
  );

  assign m_axis_tdata = {4'b0, out_data};

  // a result appears only for an item that sat in the input register
  `ASSERT_RST(a_out_from_in, clk_i, rst_ni, $rose(m_axis_tvalid) |-> $past(in_vld_q))
  // a held item is not dropped
  `ASSERT_RST(a_in_held, clk_i, rst_ni, (in_vld_q && !advance) |=> in_vld_q)
  // banks without state never raise an interrupt
  `ASSERT_RST(a_irq_live, clk_i, rst_ni,
              m_axis_tvalid |-> ((out_data.irq_lines & ~IrqLive) == '0))

endmodule
